// ===== sv/softened_gravity_accumulator_macros.svh =====
// assertion macros for the softened gravity accumulator
// included by the top level; no other dependencies
`ifndef SOFTENED_GRAVITY_ACCUMULATOR_MACROS_SVH
`define SOFTENED_GRAVITY_ACCUMULATOR_MACROS_SVH
`ifndef SYNTH
`define SGA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sga: same-cycle check failed");
`define SGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sga: next-cycle check failed");
`else
`define SGA_ASSERT_SAME(label, clk, rst, ante, cons)
`define SGA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sga_pkg.sv =====
// shared types and constants for the softened gravity accumulator
// no dependencies
`timescale 1ns / 1ps

package sga_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_TDATA_W    = 128;
  localparam int OUT_TDATA_W   = 232;
  localparam int SQRT_STEPS    = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SOFTENING = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY   = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_EPS, S_GM, S_SQRT, S_DEN_LO, S_DEN_HI,
    S_DIV, S_PP, S_CLAMP, S_ADD, S_COUNT, S_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_EPS, OP_GM, OP_SQRT, OP_DEN_LO, OP_DEN_HI,
    OP_DIV, OP_PP, OP_CLAMP, OP_ADD, OP_COUNT, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [1:0] part;
  } dp_cmd_t;

  typedef struct packed {
    logic r2_zero;
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== sv/sga_datapath.sv =====
// datapath: config registers, shared 32x32 multiplier, bit-serial sqrt and
// divider, accumulators and output register; uses sga_pkg
`timescale 1ns / 1ps

module sga_datapath import sga_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  dp_cmd_t                cmd,
  output dp_status_t             status
);

  logic [31:0]  softening;
  logic [31:0]  gravity;
  logic [31:0]  mag [3];
  logic         neg [3];
  logic [31:0]  mass;
  logic         is_approx;
  logic         last;
  logic [63:0]  r2;
  logic [63:0]  num;
  logic [63:0]  rad;
  logic [31:0]  root;
  logic [33:0]  srem;
  logic [95:0]  den;
  logic [95:0]  drem;
  logic [95:0]  quo;
  logic         big;
  logic [127:0] acc;
  logic [63:0]  contrib;
  logic [63:0]  sum [3];
  logic [15:0]  approx_tally;
  logic [15:0]  exact_tally;
  logic         overflow_seen;
  logic [224:0] out_data;

  logic [31:0]  mag_sel;
  logic         neg_sel;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  product;
  logic [35:0]  sq_sh;
  logic [35:0]  sq_trial;
  logic [96:0]  div_sh;
  logic [96:0]  div_diff;
  logic         div_ge;
  logic [127:0] acc_sh;
  logic [63:0]  limit;
  logic [63:0]  clamp_mag;
  logic         clamp_over;
  logic [63:0]  sum_sel;
  logic [63:0]  sum_raw;
  logic         sum_over;
  logic [31:0]  raw [3];

  assign raw[0] = s_tdata[31:0];
  assign raw[1] = s_tdata[63:32];
  assign raw[2] = s_tdata[95:64];

  assign mag_sel = mag[cmd.axis];
  assign neg_sel = neg[cmd.axis];
  assign sum_sel = sum[cmd.axis];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = mag_sel;
    mul_b = mag_sel;
    case (cmd.op)
      OP_GM: begin
        mul_a = gravity;
        mul_b = mass;
      end
      OP_DEN_LO: begin
        mul_a = r2[31:0];
        mul_b = root;
      end
      OP_DEN_HI: begin
        mul_a = r2[63:32];
        mul_b = root;
      end
      OP_PP: begin
        case (cmd.part)
          2'd0:    mul_a = quo[31:0];
          2'd1:    mul_a = quo[63:32];
          default: mul_a = quo[95:64];
        endcase
        mul_b = mag_sel;
      end
      default: begin
        mul_a = mag_sel;
        mul_b = mag_sel;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // one square root digit
  assign sq_sh    = {srem, rad[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};

  // one quotient bit
  assign div_sh   = {drem, num[63]};
  assign div_ge   = div_sh >= {1'b0, den};
  assign div_diff = div_sh - {1'b0, den};

  // contribution clamp
  assign acc_sh = acc >> FRAC_BITS;
  assign limit  = neg_sel ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  always_comb begin
    clamp_over = 1'b0;
    clamp_mag  = acc_sh[63:0];
    if (mag_sel == 32'd0) begin
      clamp_mag = 64'd0;
    end else if (big || acc_sh[127:64] != 64'd0 || acc_sh[63:0] > limit) begin
      clamp_over = 1'b1;
      clamp_mag  = limit;
    end
  end

  // saturating accumulate
  assign sum_raw  = sum_sel + contrib;
  assign sum_over = (sum_sel[63] == contrib[63]) && (sum_raw[63] != sum_sel[63]);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      softening <= 32'd0;
      gravity   <= 32'(64'd1 << FRAC_BITS);
    end else if (cfg_we) begin
      if (cfg_index == CFG_SOFTENING) softening <= cfg_data;
      if (cfg_index == CFG_GRAVITY)   gravity   <= cfg_data;
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= raw[i][31];
          mag[i] <= raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
        end
        mass      <= s_tdata[127:96];
        is_approx <= s_tuser;
        last      <= s_tlast;
        r2        <= 64'd0;
      end
      OP_SQ:  r2 <= r2 + product;
      OP_EPS: r2 <= r2 + ({32'd0, softening} << FRAC_BITS);
      OP_GM: begin
        num  <= product;
        rad  <= r2;
        root <= 32'd0;
        srem <= 34'd0;
      end
      OP_SQRT: begin
        rad <= {rad[61:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          srem <= 34'(sq_sh - sq_trial);
          root <= {root[30:0], 1'b1};
        end else begin
          srem <= sq_sh[33:0];
          root <= {root[30:0], 1'b0};
        end
      end
      OP_DEN_LO: begin
        den  <= {32'd0, product};
        drem <= 96'd0;
        quo  <= 96'd0;
        big  <= 1'b0;
      end
      OP_DEN_HI: den <= den + {product, 32'd0};
      OP_DIV: begin
        num  <= {num[62:0], 1'b0};
        drem <= div_ge ? div_diff[95:0] : div_sh[95:0];
        quo  <= {quo[94:0], div_ge};
        big  <= big | quo[95];
      end
      OP_PP: begin
        case (cmd.part)
          2'd0:    acc <= {64'd0, product};
          2'd1:    acc <= acc + {32'd0, product, 32'd0};
          default: acc <= acc + {product, 64'd0};
        endcase
      end
      OP_CLAMP: contrib <= neg_sel ? (~clamp_mag + 64'd1) : clamp_mag;
      default: ;
    endcase
  end

  // accumulated state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) sum[i] <= 64'd0;
      approx_tally  <= 16'd0;
      exact_tally   <= 16'd0;
      overflow_seen <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // result valid: set on emit, dropped once taken
      if (cmd.op == OP_EMIT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        OP_CLAMP: if (clamp_over) overflow_seen <= 1'b1;
        OP_ADD: begin
          if (sum_over) begin
            overflow_seen  <= 1'b1;
            sum[cmd.axis]  <= sum_sel[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            sum[cmd.axis]  <= sum_raw;
          end
        end
        OP_COUNT: begin
          if (r2 == 64'd0) overflow_seen <= 1'b1;
          if (is_approx) begin
            if (approx_tally != 16'hFFFF) approx_tally <= approx_tally + 16'd1;
          end else begin
            if (exact_tally != 16'hFFFF) exact_tally <= exact_tally + 16'd1;
          end
        end
        OP_EMIT: begin
          for (int i = 0; i < 3; i++) sum[i] <= 64'd0;
          approx_tally  <= 16'd0;
          exact_tally   <= 16'd0;
          overflow_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_data <= {overflow_seen, exact_tally, approx_tally, sum[2], sum[1], sum[0]};
    end
  end

  assign m_tdata         = {7'd0, out_data};
  assign status.r2_zero  = (r2 == 64'd0);
  assign status.last     = last;
  assign status.out_busy = m_tvalid & ~m_tready;

endmodule

// ===== sv/sga_controller.sv =====
// controller: sequences one request through the datapath steps
// uses sga_pkg
`timescale 1ns / 1ps

module sga_controller import sga_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  localparam int DIV_STEPS = 64 + 3 * FRAC_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  ctl_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [1:0]        axis, axis_next;
  logic [1:0]        part, part_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      axis  <= 2'd0;
      part  <= 2'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
      axis  <= axis_next;
      part  <= part_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    axis_next  = axis;
    part_next  = part;
    s_tready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.axis   = axis;
    cmd.part   = part;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          axis_next  = 2'd0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (axis == 2'd2) begin
          axis_next  = 2'd0;
          state_next = S_EPS;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      S_EPS: begin
        cmd.op     = OP_EPS;
        state_next = S_GM;
      end
      S_GM: begin
        cmd.op     = OP_GM;
        step_next  = '0;
        state_next = status.r2_zero ? S_COUNT : S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_DEN_LO;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DEN_LO: begin
        cmd.op     = OP_DEN_LO;
        state_next = S_DEN_HI;
      end
      S_DEN_HI: begin
        cmd.op     = OP_DEN_HI;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          step_next  = '0;
          axis_next  = 2'd0;
          part_next  = 2'd0;
          state_next = S_PP;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_PP: begin
        cmd.op = OP_PP;
        if (part == 2'd2) begin
          part_next  = 2'd0;
          state_next = S_CLAMP;
        end else begin
          part_next = part + 2'd1;
        end
      end
      S_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        if (axis == 2'd2) begin
          axis_next  = 2'd0;
          state_next = S_COUNT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_PP;
        end
      end
      S_COUNT: begin
        cmd.op     = OP_COUNT;
        state_next = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/softened_gravity_accumulator.sv =====
// channel  dir  handshake                 payload
// cfg      in   cfg_we                    cfg_index, cfg_data
// s_*      in   s_tvalid / s_tready       s_tdata, s_tuser, s_tlast
// m_*      out  m_tvalid / m_tready       m_tdata
//
// the bit-serial divider (64 + 3*FRAC_BITS steps) and the 32-step square root
// set how long an item takes; an item that ends a run also takes an emit step.
// zero distance items skip the square root and the divider.
// reset is synchronous; it clears sums, counts and softening and sets gravity to 1 << FRAC_BITS.
// a run end waits while a previous result is still held on m_*.
// top level; uses sga_pkg, sga_controller, sga_datapath and the macros header
`timescale 1ns / 1ps
`include "softened_gravity_accumulator_macros.svh"

module softened_gravity_accumulator import sga_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // offset_x, offset_y, offset_z, source_mass
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // is_approximation
  input  logic [0:0]             s_tuser,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // accel_x, accel_y, accel_z, approximation_count, exact_count, saturated
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sga_controller #(.FRAC_BITS(FRAC_BITS)) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  sga_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser[0]),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

  // checks
  `SGA_ASSERT_NEXT(a_busy_after_request, clk, rst, s_tvalid && s_tready, !s_tready)
  `SGA_ASSERT_SAME(a_result_from_emit, clk, rst, $rose(m_tvalid), $past(cmd.op == OP_EMIT))
  `SGA_ASSERT_SAME(a_emit_slot_free, clk, rst, cmd.op == OP_EMIT, !m_tvalid || m_tready)

endmodule

// ===== tb/tb_top.sv =====
// testbench for the softened gravity accumulator: directed and random interactions
// checked against a bit-exact fixed-point force predictor; uses sga_pkg and the rtl top
`timescale 1ns / 1ps

module tb_top;
  import sga_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [31:0] ONE_Q = 32'd1 << FB;

  typedef struct packed {
    logic [63:0] ax, ay, az;
    logic [15:0] n_approx, n_exact;
    logic        sat;
  } accel_sum_t;

  // force predictor and expected sums
  class accel_scoreboard;
    logic [31:0] eps_sq, grav;
    logic [63:0] acc_x, acc_y, acc_z;
    logic [15:0] cnt_approx, cnt_exact;
    logic        clipped;
    accel_sum_t  sums_due[$];
    int          errors, results_seen;

    function new();
      eps_sq = '0;
      grav = ONE_Q;
      clear_sums();
      errors = 0;
      results_seen = 0;
    endfunction

    function void clear_sums();
      acc_x = '0; acc_y = '0; acc_z = '0;
      cnt_approx = '0; cnt_exact = '0;
      clipped = 1'b0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
      if (idx == CFG_SOFTENING) eps_sq = val;
      else if (idx == CFG_GRAVITY) grav = val;
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, b;
      res = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [63:0] clip_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        clipped = 1'b1;
        return a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      end
      return s;
    endfunction

    // one axis, truncated toward zero, clamped to 64-bit signed range
    function logic [63:0] axis_pull(logic [127:0] scale, logic [31:0] raw);
      logic [63:0] mag, lim, m;
      logic [127:0] p;
      logic neg;
      neg = raw[31];
      mag = neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (mag == 0) return '0;
      if (scale[127:96] != 0) begin
        clipped = 1'b1;
        m = lim;
      end else begin
        p = (scale * {64'd0, mag}) >> FB;
        if (p[127:64] != 0 || p[63:0] > lim) begin
          clipped = 1'b1;
          m = lim;
        end else begin
          m = p[63:0];
        end
      end
      return neg ? 64'd0 - m : m;
    endfunction

    function void note_request(logic [31:0] dx, dy, dz, mass, logic approx, logic last);
      logic [63:0] mx, my, mz, r2, r;
      logic [127:0] den, num, q, rem, frac, scale;
      accel_sum_t e;
      mx = dx[31] ? (64'd1 << 32) - {32'd0, dx} : {32'd0, dx};
      my = dy[31] ? (64'd1 << 32) - {32'd0, dy} : {32'd0, dy};
      mz = dz[31] ? (64'd1 << 32) - {32'd0, dz} : {32'd0, dz};
      r2 = mx * mx + my * my + mz * mz + ({32'd0, eps_sq} << FB);
      if (r2 == 0) begin
        clipped = 1'b1;
      end else begin
        r = root_floor(r2);
        den = {64'd0, r2} * {64'd0, r};
        num = ({96'd0, grav} * {96'd0, mass}) << (2 * FB);
        q = num / den;
        rem = num % den;
        frac = (rem << FB) / den;
        scale = (q << FB) | {64'd0, frac[63:0]};
        if (q[127:128-FB] != 0) scale[127:64] = '1;
        acc_x = clip_add(acc_x, axis_pull(scale, dx));
        acc_y = clip_add(acc_y, axis_pull(scale, dy));
        acc_z = clip_add(acc_z, axis_pull(scale, dz));
      end
      if (approx) begin
        if (cnt_approx != 16'hffff) cnt_approx++;
      end else begin
        if (cnt_exact != 16'hffff) cnt_exact++;
      end
      if (last) begin
        e = '{acc_x, acc_y, acc_z, cnt_approx, cnt_exact, clipped};
        sums_due.push_back(e);
        clear_sums();
      end
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch on %s: got %h expected %h (result %0d)", field, got, want,
                 results_seen);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data);
      accel_sum_t g, e;
      g.ax = data[63:0];
      g.ay = data[127:64];
      g.az = data[191:128];
      g.n_approx = data[207:192];
      g.n_exact = data[223:208];
      g.sat = data[224];
      results_seen++;
      if (sums_due.size() == 0) begin
        report("unexpected result", g.ax, '0);
      end else begin
        e = sums_due.pop_front();
        if (g.ax !== e.ax) report("accel_x", g.ax, e.ax);
        if (g.ay !== e.ay) report("accel_y", g.ay, e.ay);
        if (g.az !== e.az) report("accel_z", g.az, e.az);
        if (g.n_approx !== e.n_approx) report("approximation_count", g.n_approx, e.n_approx);
        if (g.n_exact !== e.n_exact) report("exact_count", g.n_exact, e.n_exact);
        if (g.sat !== e.sat) report("saturated", g.sat, e.sat);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  accel_scoreboard sb;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int requests_sent = 0;

  always #5 clk = ~clk;

  softened_gravity_accumulator dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata
  );

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task send_request(logic [31:0] dx, dy, dz, mass, logic approx, logic last);
    int n;
    s_tvalid <= 1'b1;
    s_tdata <= {mass, dz, dy, dx};
    s_tuser <= approx;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_request(dx, dy, dz, mass, approx, last);
    requests_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk);
    end
  endtask

  // let the block finish all work before touching registers
  task drain();
    s_tvalid <= 1'b0;
    while (sb.sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [31:0] rand_offset();
    logic [31:0] v;
    int k;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: v = '0;
      default: begin
        k = $urandom_range(6, 24);
        v = $urandom & ((32'd1 << k) - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function logic [31:0] rand_mass();
    int k;
    if ($urandom_range(0, 7) == 0) return $urandom;
    k = $urandom_range(4, 24);
    return $urandom & ((32'd1 << k) - 1);
  endfunction

  task random_runs(int n_items);
    int left, len, i;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (i = 0; i < len; i++)
        send_request(rand_offset(), rand_offset(), rand_offset(), rand_mass(),
                     1'($urandom_range(0, 1)), i == len - 1);
      left -= len;
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero distance, extremes, huge pulls, sum overflow
    send_request('0, '0, '0, 32'h0001_0000, 1'b0, 1'b1);
    send_request(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b0);
    send_request(32'h0001_0000, '0, '0, 32'h0001_0000, 1'b0, 1'b0);
    send_request('0, 32'hffff_0000, '0, 32'h0002_0000, 1'b1, 1'b1);
    send_request(32'd1, 32'd1, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
    send_request(32'd1, 32'd1, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
    send_request(32'd1, '0, '0, 32'hffff_ffff, 1'b1, 1'b1);
    send_request('0, '0, '0, '0, 1'b1, 1'b0);
    send_request(32'h0000_0100, 32'hffff_ff00, 32'h0000_0001, '0, 1'b0, 1'b1);
    send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
    drain();

    write_reg(CFG_SOFTENING, 32'hffff_ffff);
    write_reg(CFG_GRAVITY, 32'hffff_ffff);
    write_reg(CFG_SPARE, 32'h1234_5678);
    send_request('0, '0, '0, 32'hffff_ffff, 1'b0, 1'b0);
    send_request(32'd1, 32'hffff_ffff, '0, 32'hffff_ffff, 1'b1, 1'b1);
    random_runs(300);
    drain();

    write_reg(CFG_SOFTENING, '0);
    write_reg(CFG_GRAVITY, '0);
    send_request(32'h0001_0000, '0, '0, 32'hffff_ffff, 1'b0, 1'b1);
    random_runs(100);
    drain();

    // long receiver hold-off while items keep coming
    write_reg(CFG_SOFTENING, 32'h0000_0100);
    write_reg(CFG_GRAVITY, ONE_Q);
    hold_req = 1'b1;
    random_runs(400);
    drain();

    write_reg(CFG_SOFTENING, $urandom);
    write_reg(CFG_GRAVITY, $urandom);
    random_runs(400);
    drain();

    write_reg(CFG_SOFTENING, 32'd1);
    write_reg(CFG_GRAVITY, 32'h0000_4000);
    random_runs(400);
    drain();

    // closing part runs without idling
    write_reg(CFG_SOFTENING, $urandom_range(0, 65535));
    write_reg(CFG_GRAVITY, ONE_Q);
    quiet = 1'b1;
    random_runs(330);
    drain();

    $display("sent %0d interactions over 7 register settings, checked %0d sums, %0d mismatches",
             requests_sent, sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== softened_gravity_accumulator.f =====
+incdir+sv
sv/sga_pkg.sv
sv/sga_datapath.sv
sv/sga_controller.sv
sv/softened_gravity_accumulator.sv
tb/tb_top.sv
